### src/io_port_range_allocator_core_assert.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by the top level.
`ifndef IO_PORT_RANGE_ALLOCATOR_CORE_ASSERT_SVH
`define IO_PORT_RANGE_ALLOCATOR_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define IPRA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipra check failed");
// implication with the consequent checked in the next cycle
`define IPRA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipra check failed");
`endif

### src/ipra_pkg.sv
// Package for the I/O port range allocator: sizes, codes, types.
// No dependencies.
package ipra_pkg;
   localparam int MaxRanges = 32;
   localparam int IdxW = $clog2(MaxRanges);
   localparam int CntW = $clog2(MaxRanges + 1);
   localparam logic [16:0] PortSpace = 17'h10000;
   localparam logic [16:0] SearchBase = 17'h00400;
   localparam logic [16:0] VgaLoStart = 17'h002b0;
   localparam logic [16:0] VgaLoEnd = 17'h002e0;
   localparam logic [16:0] VgaHiStart = 17'h003c0;
   localparam logic [16:0] VgaHiEnd = 17'h003db;

   localparam logic [2:0] OP_FIXED = 3'd0;
   localparam logic [2:0] OP_ALLOC = 3'd1;
   localparam logic [2:0] OP_RESV = 3'd2;
   localparam logic [2:0] OP_FREE = 3'd3;
   localparam logic [2:0] OP_CHECK = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FAIL = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [15:0] start;
      logic [16:0] stop;
      logic reserved;
   } entry_type;

   // table write command from the sequencer
   typedef struct packed {
      logic we;
      logic [IdxW-1:0] addr;
      entry_type data;
   } tbl_cmd_type;
endpackage

### src/ipra_table.sv
// Range table memory: one write port, one registered read port.
// Depends on ipra_pkg.
module ipra_table (
   input logic clock,
   input ipra_pkg::tbl_cmd_type cmd,
   input logic [ipra_pkg::IdxW-1:0] raddr,
   output ipra_pkg::entry_type rdata
);
   import ipra_pkg::*;
   entry_type mem [MaxRanges];

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.addr] <= cmd.data;
      end
      rdata <= mem[raddr];
   end
endmodule

### src/ipra_roundup.sv
// Iterative round-up of a value to a multiple of align, restoring division.
// Depends on ipra_pkg.
module ipra_roundup (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [16:0] value,
   input logic [15:0] align,
   output logic done,
   output logic [16:0] result
);
   import ipra_pkg::*;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [16:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] num_ff, num_in;
   logic [16:0] trial;
   logic [33:0] prod;

   always_comb begin
      trial = {rem_ff[15:0], num_ff[16]};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      done = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = 5'd0;
         quo_in = '0;
         rem_in = '0;
         num_in = value + 17'({1'b0, align}) - 17'd1;
      end else if (busy_ff) begin
         if (cnt_ff == 5'd17) begin
            busy_in = 1'b0;
            done = 1'b1;
         end else begin
            num_in = {num_ff[15:0], 1'b0};
            if (trial >= {1'b0, align}) begin
               rem_in = trial - {1'b0, align};
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[15:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
         end
      end
      prod = quo_ff * {1'b0, align};
      result = prod[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
   end
endmodule

### src/io_port_range_allocator_core.sv
// Top level of the I/O port range allocator: request sequencer and table walk.
// Depends on ipra_pkg, ipra_table, ipra_roundup, the assertion header.
//
// channel | dir | fields (low bit first)
// req     | in  | tdata: operation[2:0] port[18:3] size[35:19] align[51:36] range_end[68:52]
// rsp     | out | tdata: result_port[15:0] status[17:16] allowed[18]
//
// One request at a time; a walk reads one table entry through the registered read
// port per pass through S_RD and S_EVAL, and each aligned round-up waits in S_DIV
// for the divider. Inserts and frees shift entries one at a time (S_SHRD, S_SHWR).
// Synchronous reset empties the table at once (count to zero).
// req_tready stays low until the response has been taken.
module io_port_range_allocator_core (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [71:0] req_tdata, // operation, port, size, align, range_end
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [23:0] rsp_tdata // result_port, status, allowed
);
   import ipra_pkg::*;
   `include "io_port_range_allocator_core_assert.svh"

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD = 4'd1;
   localparam logic [3:0] S_EVAL = 4'd2;
   localparam logic [3:0] S_DIV = 4'd3;
   localparam logic [3:0] S_SHRD = 4'd4;
   localparam logic [3:0] S_SHWR = 4'd5;
   localparam logic [3:0] S_INS = 4'd6;
   localparam logic [3:0] S_RSP = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic [2:0] op_ff;
   logic [15:0] port_ff;
   logic [16:0] size_ff, end_ff;
   logic [15:0] align_ff;
   logic [16:0] cand_ff, cand_in;
   logic okc_ff, okc_in;
   logic [15:0] rport_ff, rport_in;
   logic [1:0] rstat_ff, rstat_in;
   logic rallow_ff, rallow_in;
   logic insres_ff, insres_in;
   logic shdown_ff, shdown_in;
   tbl_cmd_type cmd;
   logic [IdxW-1:0] raddr;
   entry_type rd;
   logic div_start, div_done;
   logic [16:0] div_res;
   logic [17:0] lim;
   logic [17:0] gap;

   ipra_table u_table (.clock(clock), .cmd(cmd), .raddr(raddr), .rdata(rd));
   ipra_roundup u_round (.clock(clock), .reset(reset), .start(div_start),
      .value(rd.stop), .align(align_ff), .done(div_done), .result(div_res));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RSP);
   assign rsp_tdata = {5'd0, rallow_ff, rstat_ff, rport_ff};
   // full sum: port plus size may pass 17 bits
   assign lim = {2'b0, port_ff} + {1'b0, size_ff};
   assign gap = {2'b0, rd.start} - {1'b0, cand_ff};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      cand_in = cand_ff;
      okc_in = okc_ff;
      rport_in = rport_ff;
      rstat_in = rstat_ff;
      rallow_in = rallow_ff;
      insres_in = insres_ff;
      shdown_in = shdown_ff;
      cmd = '0;
      raddr = idx_ff[IdxW-1:0];
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               idx_in = '0;
               cand_in = SearchBase;
               okc_in = 1'b1;
               rport_in = '0;
               rstat_in = ST_FAIL;
               rallow_in = 1'b0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            // entry at idx_ff is being read; decide on missing entries first
            if (idx_ff >= count_ff) begin
               state_in = S_RSP;
               case (op_ff)
                  OP_FIXED: begin
                     if (lim > {1'b0, PortSpace}) begin
                        state_in = S_RSP;
                     end else begin
                        pos_in = idx_ff;
                        cand_in = {1'b0, port_ff};
                        insres_in = 1'b0;
                        state_in = S_INS;
                     end
                  end
                  OP_FREE: begin
                     rport_in = port_ff;
                     rstat_in = ST_OK;
                  end
                  OP_CHECK: begin
                     rport_in = port_ff;
                     rstat_in = ST_OK;
                     rallow_in = okc_ff;
                  end
                  default: ;
               endcase
            end else if (op_ff == OP_FIXED && lim > {1'b0, PortSpace}) begin
               state_in = S_RSP;
            end else if (op_ff == OP_CHECK && (({1'b0, port_ff} >= VgaLoStart
                  && end_ff <= VgaLoEnd) || ({1'b0, port_ff} >= VgaHiStart
                  && end_ff <= VgaHiEnd))) begin
               rport_in = port_ff;
               rstat_in = ST_OK;
               rallow_in = 1'b1;
               state_in = S_RSP;
            end else if (op_ff > OP_CHECK) begin
               state_in = S_RSP;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_RD;
            idx_in = idx_ff + 1'b1;
            case (op_ff)
               OP_FIXED: begin
                  if (rd.stop > {1'b0, port_ff}) begin
                     if (rd.reserved && rd.start == port_ff && {1'b0, rd.stop} == lim) begin
                        cmd.we = 1'b1;
                        cmd.addr = idx_ff[IdxW-1:0];
                        cmd.data = rd;
                        cmd.data.reserved = 1'b0;
                        rport_in = port_ff;
                        rstat_in = ST_OK;
                        state_in = S_RSP;
                     end else if ({2'b0, rd.start} >= lim) begin
                        pos_in = idx_ff;
                        cand_in = {1'b0, port_ff};
                        insres_in = 1'b0;
                        state_in = S_INS;
                     end else begin
                        state_in = S_RSP;
                     end
                  end
               end
               OP_ALLOC, OP_RESV: begin
                  if ({1'b0, rd.start} >= SearchBase) begin
                     if (!gap[17] && gap[16:0] > size_ff) begin
                        pos_in = idx_ff;
                        insres_in = (op_ff == OP_RESV);
                        state_in = S_INS;
                     end else if (align_ff != '0) begin
                        div_start = 1'b1;
                        idx_in = idx_ff;
                        state_in = S_DIV;
                     end else begin
                        cand_in = rd.stop;
                     end
                  end
               end
               OP_FREE: begin
                  if (rd.start == port_ff) begin
                     count_in = count_ff - 1'b1;
                     pos_in = idx_ff;
                     shdown_in = 1'b1;
                     rport_in = port_ff;
                     rstat_in = ST_OK;
                     state_in = S_SHRD;
                  end else if (rd.start > port_ff) begin
                     rport_in = port_ff;
                     rstat_in = ST_OK;
                     state_in = S_RSP;
                  end
               end
               default: begin
                  if (({1'b0, port_ff} >= {1'b0, rd.start} && {1'b0, port_ff} < rd.stop)
                        || (port_ff <= rd.start && end_ff > {1'b0, rd.start})) begin
                     rport_in = port_ff;
                     rstat_in = ST_OK;
                     rallow_in = 1'b0;
                     state_in = S_RSP;
                  end else begin
                     okc_in = 1'b1;
                  end
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               cand_in = div_res;
               idx_in = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_INS: begin
            rport_in = cand_ff[15:0];
            if (count_ff >= CntW'(MaxRanges)) begin
               rstat_in = ST_FULL;
               state_in = S_RSP;
            end else begin
               rstat_in = ST_OK;
               shdown_in = 1'b0;
               idx_in = count_ff;
               count_in = count_ff + 1'b1;
               state_in = S_SHRD;
            end
         end
         S_SHRD: begin
            // shifting: up moves idx-1 to idx, down moves pos+1 to pos
            if (shdown_ff) begin
               raddr = IdxW'(pos_ff + 1'b1);
               state_in = (pos_ff >= count_ff) ? S_RSP : S_SHWR;
            end else begin
               raddr = IdxW'(idx_ff - 1'b1);
               if (idx_ff == pos_ff) begin
                  cmd.we = 1'b1;
                  cmd.addr = pos_ff[IdxW-1:0];
                  cmd.data.start = cand_ff[15:0];
                  cmd.data.stop = cand_ff + size_ff;
                  cmd.data.reserved = insres_ff;
                  state_in = S_RSP;
               end else begin
                  state_in = S_SHWR;
               end
            end
         end
         S_SHWR: begin
            cmd.we = 1'b1;
            cmd.data = rd;
            state_in = S_SHRD;
            if (shdown_ff) begin
               cmd.addr = pos_ff[IdxW-1:0];
               pos_in = pos_ff + 1'b1;
            end else begin
               cmd.addr = idx_ff[IdxW-1:0];
               idx_in = idx_ff - 1'b1;
            end
         end
         S_RSP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      if (state_ff == S_IDLE && req_tvalid) begin
         op_ff <= req_tdata[2:0];
         port_ff <= req_tdata[18:3];
         size_ff <= req_tdata[35:19];
         align_ff <= req_tdata[51:36];
         end_ff <= req_tdata[68:52];
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      cand_ff <= cand_in;
      okc_ff <= okc_in;
      rport_ff <= rport_in;
      rstat_ff <= rstat_in;
      rallow_ff <= rallow_in;
      insres_ff <= insres_in;
      shdown_ff <= shdown_in;
   end

   `IPRA_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CntW'(MaxRanges))
   `IPRA_ASSERT_IMP(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   `IPRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
endmodule
